// ----- rtl/shld_pkg.sv -----
// Shared types and constants for the sync header length deframer.
`timescale 1ns / 1ps
`default_nettype none

package shld_pkg;

    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CNT_W       = 16;
    localparam int LEN_W       = 16;
    localparam int OFF_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THIRD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FOURTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_OFFSET = 3'd4;

    localparam logic [OFF_W-1:0] LENGTH_OFFSET_RESET = 6'd8;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
        logic               error;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } q_head_t;

endpackage

`default_nettype wire

// ----- rtl/shld_front.sv -----
// Front end: configuration registers, start-pattern hunt and header/payload sequencing.
`timescale 1ns / 1ps
`default_nettype none

module shld_front #(
    parameter int HEADER_BYTES = 32,
    parameter int MAX_PAYLOAD  = 1024
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [shld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [shld_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  [shld_pkg::BYTE_W-1:0]          rx_byte,
    input  wire                                  q_full,
    output logic                                 push,
    output shld_pkg::out_word_t                  push_word
);
    import shld_pkg::*;

    localparam logic [CNT_W-1:0] HDR_LAST_IDX = CNT_W'(HEADER_BYTES - 1);
    localparam logic [LEN_W-1:0] HDR_LEN      = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W:0]   LONG_LIMIT   = (LEN_W + 1)'(HEADER_BYTES + MAX_PAYLOAD);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC1,
        ST_SYNC2,
        ST_SYNC3,
        ST_HEADER,
        ST_PAYLOAD
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   tl_reg, tl_next;
    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    logic [BYTE_W-1:0]  sync_third_reg;
    logic [BYTE_W-1:0]  sync_fourth_reg;
    logic [OFF_W-1:0]   length_offset_reg;

    logic               accept;
    logic               has_word;
    logic [BYTE_W-1:0]  expect_byte;
    logic [LEN_W-1:0]   tl_cap;
    out_word_t          word;

    function automatic logic [LEN_W-1:0] capture(
        input logic [CNT_W-1:0]  idx,
        input logic [BYTE_W-1:0] b,
        input logic [LEN_W-1:0]  tl,
        input logic [OFF_W-1:0]  off
    );
        logic [LEN_W-1:0] res;
        res = tl;
        if (idx == CNT_W'(off))
        begin
            res = {b, tl[BYTE_W-1:0]};
        end
        else if (idx == CNT_W'(off) + CNT_W'(1))
        begin
            res = {tl[LEN_W-1:BYTE_W], b};
        end
        return res;
    endfunction

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && has_word;
    assign push_word = word;

    always_comb
    begin
        case (state_reg)
            ST_SYNC1: expect_byte = sync_second_reg;
            ST_SYNC2: expect_byte = sync_third_reg;
            default:  expect_byte = sync_fourth_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        tl_next         = tl_reg;
        has_word        = 1'b0;
        tl_cap          = capture(cnt_reg, rx_byte, tl_reg, length_offset_reg);
        word.kind       = KIND_HEADER;
        word.byte_value = rx_byte;
        word.byte_index = cnt_reg[INDEX_W-1:0];
        word.last       = 1'b0;
        word.error      = 1'b0;
        case (state_reg)
            ST_SYNC1, ST_SYNC2, ST_SYNC3:
            begin
                if (rx_byte == expect_byte)
                begin
                    tl_next    = tl_cap;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = state_t'(state_reg + 3'd1);
                end
                else if (rx_byte == sync_first_reg)
                begin
                    tl_next    = capture('0, rx_byte, '0, length_offset_reg);
                    cnt_next   = CNT_W'(1);
                    state_next = ST_SYNC1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_HUNT;
                end
            end
            ST_HEADER:
            begin
                has_word = 1'b1;
                tl_next  = tl_cap;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg >= HDR_LAST_IDX)
                begin
                    if (tl_cap <= HDR_LEN)
                    begin
                        word.last  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_HUNT;
                    end
                    else if ({1'b0, tl_cap} > LONG_LIMIT)
                    begin
                        word.last  = 1'b1;
                        word.error = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                has_word  = 1'b1;
                word.kind = KIND_PAYLOAD;
                cnt_next  = cnt_reg + CNT_W'(1);
                if ({1'b0, cnt_reg} + (CNT_W + 1)'(1) >= {1'b0, tl_reg})
                begin
                    word.last  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_HUNT;
                end
            end
            default:
            begin
                if (rx_byte == sync_first_reg)
                begin
                    tl_next    = capture('0, rx_byte, '0, length_offset_reg);
                    cnt_next   = CNT_W'(1);
                    state_next = ST_SYNC1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_HUNT;
            cnt_reg           <= '0;
            tl_reg            <= '0;
            sync_first_reg    <= '0;
            sync_second_reg   <= '0;
            sync_third_reg    <= '0;
            sync_fourth_reg   <= '0;
            length_offset_reg <= LENGTH_OFFSET_RESET;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
                tl_reg    <= tl_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYNC_FIRST:    sync_first_reg    <= cfg_data[BYTE_W-1:0];
                    REG_SYNC_SECOND:   sync_second_reg   <= cfg_data[BYTE_W-1:0];
                    REG_SYNC_THIRD:    sync_third_reg    <= cfg_data[BYTE_W-1:0];
                    REG_SYNC_FOURTH:   sync_fourth_reg   <= cfg_data[BYTE_W-1:0];
                    REG_LENGTH_OFFSET: length_offset_reg <= cfg_data[OFF_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/shld_queue.sv -----
// Short word queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module shld_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  shld_pkg::out_word_t  push_word,
    output logic                 full,
    input  wire                  pop,
    output shld_pkg::q_head_t    head
);
    import shld_pkg::*;

    out_word_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.word  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/shld_back.sv -----
// Output stage: registered result word with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

module shld_back (
    input  wire                                clk,
    input  wire                                rst_n,
    input  shld_pkg::q_head_t                  head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               kind,
    output logic [shld_pkg::BYTE_W-1:0]        byte_value,
    output logic [shld_pkg::INDEX_W-1:0]       byte_index,
    output logic                               last,
    output logic                               error
);
    import shld_pkg::*;

    logic      valid_reg, valid_next;
    out_word_t word_reg;

    assign pop        = head.valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    assign out_valid  = valid_reg;
    assign kind       = word_reg.kind;
    assign byte_value = word_reg.byte_value;
    assign byte_index = word_reg.byte_index;
    assign last       = word_reg.last;
    assign error      = word_reg.error;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= head.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sync_header_length_deframer.sv -----
// Top level of the sync header length deframer.
//
//  Channel   Signals                                          Direction
//  --------  -----------------------------------------------  ---------
//  config    cfg_we, cfg_index, cfg_data                      in
//  input     in_valid, in_ready, rx_byte                      in
//  output    out_valid, out_ready, kind, byte_value,          out
//            byte_index, last, error
//
//  One byte is accepted per cycle while in_ready is high; a word goes into
//  the queue at the edge that accepts its byte, and from the queue into
//  the output register.
//  A two-word queue sits between the sequencer and the output register, so
//  in_ready drops only when that queue is full under output stall.
//  Reset clears the sequencer to hunting, the sync bytes to zero and the
//  length offset to eight.
`timescale 1ns / 1ps
`default_nettype none

module sync_header_length_deframer #(
    parameter int HEADER_BYTES = 32,
    parameter int MAX_PAYLOAD  = 1024
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [shld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [shld_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [shld_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               kind,
    output logic [shld_pkg::BYTE_W-1:0]        byte_value,
    output logic [shld_pkg::INDEX_W-1:0]       byte_index,
    output logic                               last,
    output logic                               error
);
    import shld_pkg::*;

    logic      q_full;
    logic      push;
    logic      pop;
    out_word_t push_word;
    q_head_t   head;

    shld_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    shld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    shld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .last       (last),
        .error      (error)
    );

endmodule

`default_nettype wire
